### src/linear_probe_hash_table_top_macros.svh
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lpht_pkg.sv
// Package: shared types, codes, microcode table and key helper for the hash table.
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int KEY_BYTES_DEF = 8;
  localparam int KEY_W         = 64;
  localparam int SLOT_IN_W     = 6;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int SLOT_OUT_W    = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  // Sequencer steps
  typedef enum logic [1:0] {
    UC_CLR,
    UC_IDLE,
    UC_EVAL,
    UC_PUSH
  } step_t;

  // Jump conditions
  typedef enum logic [1:0] {
    C_CLR_LAST,
    C_IN_ACC,
    C_RESOLVED,
    C_OUT_FREE
  } cond_t;

  // One control word
  typedef struct packed {
    cond_t cond;
    step_t on_true;
    step_t on_false;
    logic  ld_in;
    logic  clr_wr;
    logic  probe;
    logic  push;
  } ucw_t;

  // Control store
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    w = '0;
    unique case (s)
      UC_CLR: begin
        w = '{cond: C_CLR_LAST, on_true: UC_IDLE, on_false: UC_CLR,
              ld_in: 1'b0, clr_wr: 1'b1, probe: 1'b0, push: 1'b0};
      end
      UC_IDLE: begin
        w = '{cond: C_IN_ACC, on_true: UC_EVAL, on_false: UC_IDLE,
              ld_in: 1'b1, clr_wr: 1'b0, probe: 1'b0, push: 1'b0};
      end
      UC_EVAL: begin
        w = '{cond: C_RESOLVED, on_true: UC_PUSH, on_false: UC_EVAL,
              ld_in: 1'b0, clr_wr: 1'b0, probe: 1'b1, push: 1'b0};
      end
      UC_PUSH: begin
        w = '{cond: C_OUT_FREE, on_true: UC_IDLE, on_false: UC_PUSH,
              ld_in: 1'b0, clr_wr: 1'b0, probe: 1'b0, push: 1'b1};
      end
    endcase
    return w;
  endfunction

  // Keep the low nbytes bytes, cleared from the first zero byte on (C string rules)
  function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw,
                                                     input int nbytes);
    logic [KEY_W-1:0] k;
    logic             alive;
    k     = '0;
    alive = 1'b1;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (raw[8*b +: 8] == 8'h00) alive = 1'b0;
      if (alive && (b < nbytes)) k[8*b +: 8] = raw[8*b +: 8];
    end
    return k;
  endfunction

endpackage

### src/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/linear_probe_hash_table_top.sv
// Top level: linear-probing hash table run by a microcoded sequencer.
// After rst the sequencer clears the slot RAM, one slot a cycle, up to the last slot.
// An item makes 1..SLOTS probes and is accepted only in the idle step, so a new item waits
// until the last one is pushed; each probe is one RAM read, so the probe loop sets the rate.
// The result is registered at the last probe and moved to the output word in the push step,
// which holds while the previous word still waits for out_ready.
`timescale 1ns / 1ps
`include "linear_probe_hash_table_top_macros.svh"

module linear_probe_hash_table_top #(
  parameter int SLOTS     = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BYTES = lpht_pkg::KEY_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [lpht_pkg::KEY_W-1:0]      key_bytes,
  input  logic [lpht_pkg::SLOT_IN_W-1:0]  start_slot,
  input  logic [lpht_pkg::VALUE_W-1:0]    value_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]   status,
  output logic [lpht_pkg::VALUE_W-1:0]    found_value,
  output logic [lpht_pkg::SLOT_OUT_W-1:0] slot_used
);

  import lpht_pkg::*;

  localparam int SW    = $clog2(SLOTS);
  localparam int KW    = 8 * KEY_BYTES;
  localparam int MW    = 1 + KW + VALUE_W;
  localparam logic [SW-1:0]    LAST_SLOT = SW'(SLOTS - 1);

  // start_slot mod SLOTS as a constant lookup over all input codes
  function automatic logic [SW-1:0] start_mod(input logic [SLOT_IN_W-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << SLOT_IN_W); i++) begin
      if (v == SLOT_IN_W'(i)) r = SW'(i % SLOTS);
    end
    return r;
  endfunction

  // Sequencer and datapath registers
  step_t             step, step_next;
  logic [SW-1:0]     idx;
  logic [SW-1:0]     cnt;
  op_t               op_r;
  logic [KW-1:0]     key_r;
  logic [VALUE_W-1:0] val_r;
  status_t           res_status;
  logic [VALUE_W-1:0] res_value;
  logic [SW-1:0]     res_slot;
  status_t           out_status;

  ucw_t              ucw;
  logic              go;
  logic [SW-1:0]     idx_inc;
  logic [KW-1:0]     key_norm;

  // Slot RAM: {valid, key, value}
  logic              wr_en;
  logic [MW-1:0]     wr_data;
  logic [SW-1:0]     rd_addr;
  logic [MW-1:0]     rd_data;
  logic              rd_valid;
  logic [KW-1:0]     rd_key;
  logic [VALUE_W-1:0] rd_val;

  logic              hit, empty, last, resolved, out_free, wr_put;

  lpht_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_valid = rd_data[MW-1];
  assign rd_key   = rd_data[MW-2:VALUE_W];
  assign rd_val   = rd_data[VALUE_W-1:0];
  assign key_norm = KW'(normalize_key(key_bytes, KEY_BYTES));
  assign idx_inc  = (idx == LAST_SLOT) ? '0 : idx + 1'b1;

  // Probe evaluation
  assign hit      = rd_valid && (rd_key == key_r);
  assign empty    = !rd_valid;
  assign last     = (cnt == LAST_SLOT);
  assign resolved = empty || hit || last;
  assign out_free = !out_valid || out_ready;

  // Memory write: clearing pass, or put into an empty or matching slot
  assign wr_put  = ucw.probe && (op_r == OP_PUT) && (empty || hit);
  assign wr_en   = ucw.clr_wr || wr_put;
  assign wr_data = ucw.clr_wr ? '0 : {1'b1, key_r, val_r};

  // Read the start slot on accept, else the next slot in the probe run
  assign rd_addr = ucw.ld_in ? start_mod(start_slot) : idx_inc;

  // Step decode and next step
  always_comb begin
    ucw      = ucode(step);
    in_ready = ucw.ld_in;
    unique case (ucw.cond)
      C_CLR_LAST: go = (idx == LAST_SLOT);
      C_IN_ACC:   go = in_valid;
      C_RESOLVED: go = resolved;
      C_OUT_FREE: go = out_free;
    endcase
    step_next = go ? ucw.on_true : ucw.on_false;
  end

  // Step register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= UC_CLR;
      idx       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (ucw.clr_wr) idx <= idx_inc;
      if (ucw.ld_in && in_valid) begin
        idx <= start_mod(start_slot);
        cnt <= '0;
      end
      if (ucw.probe && !resolved) begin
        idx <= idx_inc;
        cnt <= cnt + 1'b1;
      end
      if (ucw.push && out_free) out_valid <= 1'b1;
      else if (out_ready)       out_valid <= 1'b0;
    end
  end

  // Item capture, result build and output word
  always_ff @(posedge clk) begin
    if (ucw.ld_in && in_valid) begin
      op_r  <= op_t'(operation);
      key_r <= key_norm;
      val_r <= value_handle;
    end
    if (ucw.probe && resolved) begin
      if (hit) begin
        res_status <= ST_OK;
        res_value  <= (op_r == OP_GET) ? rd_val : '0;
        res_slot   <= idx;
      end else if (empty && (op_r == OP_PUT)) begin
        res_status <= ST_OK;
        res_value  <= '0;
        res_slot   <= idx;
      end else begin
        res_status <= (op_r == OP_PUT) ? ST_FULL : ST_MISS;
        res_value  <= '0;
        res_slot   <= '0;
      end
    end
    if (ucw.push && out_free) begin
      out_status  <= res_status;
      found_value <= res_value;
      slot_used   <= SLOT_OUT_W'(res_slot);
    end
  end

  assign status = out_status;

  // Checks
  `LPHT_ASSERT_NOW(a_wr_step, wr_en, step == UC_CLR || step == UC_EVAL, "RAM write outside clear or probe")
  `LPHT_ASSERT_NEXT(a_probe_adv, step == UC_EVAL && !resolved, step == UC_EVAL && cnt == $past(cnt) + 1'b1, "probe run did not advance")
  `LPHT_ASSERT_NOW(a_found_ok, out_valid && found_value != '0, status == ST_OK, "value returned with failing status")
  `LPHT_ASSERT_NOW(a_fail_zero, out_valid && status != ST_OK, found_value == '0 && slot_used == '0, "failing word carries data")

endmodule
